>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/icbad_pkg.sv
// Shared constants and types of the icon block-average downscaler.
`default_nettype none

package icbad_pkg;

   localparam int PIXEL_IN_W = 8;
   localparam int ROW_W      = 6;
   localparam int COL_W      = 6;
   localparam int MEAN_W     = 8;
   localparam int DIM_REG_W  = 13;
   localparam int CSR_IDX_W  = 4;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_COLS = CSR_IDX_W'(1);

   localparam logic [DIM_REG_W-1:0] DIM_RESET = DIM_REG_W'(64);

   typedef struct packed {
      logic [ROW_W-1:0] icon_row;
      logic [COL_W-1:0] icon_col;
      logic             frame_done;
   } cell_tag_type;

endpackage

`default_nettype wire

>>> rtl/core/icbad_ifs.sv
// Channel interfaces: pixel request, cell response and register write.
`default_nettype none

interface icbad_req_if import icbad_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [PIXEL_IN_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface icbad_rsp_if import icbad_pkg::*;;
   logic              valid;
   logic              ready;
   logic [ROW_W-1:0]  icon_row;
   logic [COL_W-1:0]  icon_col;
   logic [MEAN_W-1:0] mean_level;
   logic              frame_done;

   modport source (output valid, output icon_row, output icon_col, output mean_level,
                   output frame_done, input ready);
   modport sink   (input valid, input icon_row, input icon_col, input mean_level,
                   input frame_done, output ready);
endinterface

interface icbad_csr_if import icbad_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_REG_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/core/icbad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module icbad_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word when it hits the address being written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/icbad_geom.sv
// Dimension registers and block-size computation (reciprocal multiply by the icon size).
`default_nettype none

module icbad_geom import icbad_pkg::*; #(
   parameter int ICON_SIZE = 64,
   parameter int MAX_DIM   = 4096,
   parameter int DIM_W     = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [DIM_REG_W-1:0] wr_data,
   output logic                 restart,
   output logic                 busy,
   output logic [DIM_W-1:0]     rows,
   output logic [DIM_W-1:0]     cols,
   output logic [DIM_W-1:0]     base_row,
   output logic [DIM_W-1:0]     last_row,
   output logic [DIM_W-1:0]     base_col,
   output logic [DIM_W-1:0]     last_col
);

   // floor(n / ICON_SIZE) == (n * RECIP) >> DIV_SH for every DIM_W-bit n
   localparam int          DIV_SH = DIM_W + $clog2(ICON_SIZE);
   localparam int          PROD_W = 2 * DIM_W + 1;
   localparam logic [63:0] RECIP  = ((64'd1 << DIV_SH) + 64'(ICON_SIZE) - 64'd1)
                                    / 64'(ICON_SIZE);

   localparam logic [1:0] G_LOAD = 2'd0;
   localparam logic [1:0] G_DIV  = 2'd1;
   localparam logic [1:0] G_FIN  = 2'd2;
   localparam logic [1:0] G_IDLE = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [DIM_REG_W-1:0] raw_ff  [2];
   logic [DIM_REG_W-1:0] raw_in  [2];
   logic [DIM_W-1:0]     dim_ff  [2];
   logic [DIM_W-1:0]     dim_in  [2];
   logic [DIM_W-1:0]     quo_ff  [2];
   logic [DIM_W-1:0]     quo_in  [2];
   logic [DIM_W-1:0]     last_ff [2];
   logic [DIM_W-1:0]     last_in [2];
   logic [PROD_W-1:0]    prod    [2];

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w < 32'(ICON_SIZE)) begin
         clamp_dim = DIM_W'(ICON_SIZE);
      end else if (w > 32'(MAX_DIM)) begin
         clamp_dim = DIM_W'(MAX_DIM);
      end else begin
         clamp_dim = DIM_W'(w);
      end
   endfunction

   assign restart = wr_en && (wr_index == REG_IMAGE_ROWS || wr_index == REG_IMAGE_COLS);
   assign busy    = (state_ff != G_IDLE);

   always_comb begin
      state_in = state_ff;
      raw_in   = raw_ff;
      dim_in   = dim_ff;
      quo_in   = quo_ff;
      last_in  = last_ff;

      for (int l = 0; l < 2; l++) begin
         prod[l] = PROD_W'(dim_ff[l]) * PROD_W'(RECIP);
      end

      case (state_ff)
         G_LOAD: begin
            for (int l = 0; l < 2; l++) begin
               dim_in[l] = clamp_dim(raw_ff[l]);
            end
            state_in = G_DIV;
         end
         G_DIV: begin
            // block size: clamped dimension over the icon size
            for (int l = 0; l < 2; l++) begin
               quo_in[l] = DIM_W'(prod[l] >> DIV_SH);
            end
            state_in = G_FIN;
         end
         G_FIN: begin
            // last block takes the leftover lines or pixels
            for (int l = 0; l < 2; l++) begin
               last_in[l] = DIM_W'(32'(dim_ff[l]) - 32'(ICON_SIZE - 1) * 32'(quo_ff[l]));
            end
            state_in = G_IDLE;
         end
         G_IDLE: begin
         end
         default: begin
            state_in = G_LOAD;
         end
      endcase

      if (wr_en && wr_index == REG_IMAGE_ROWS) begin
         raw_in[0] = wr_data;
      end
      if (wr_en && wr_index == REG_IMAGE_COLS) begin
         raw_in[1] = wr_data;
      end
      if (restart) begin
         state_in = G_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= G_LOAD;
         raw_ff[0] <= DIM_RESET;
         raw_ff[1] <= DIM_RESET;
      end else begin
         state_ff <= state_in;
         raw_ff   <= raw_in;
      end
   end

   always_ff @(posedge clock) begin
      dim_ff  <= dim_in;
      quo_ff  <= quo_in;
      last_ff <= last_in;
   end

   assign rows     = dim_ff[0];
   assign cols     = dim_ff[1];
   assign base_row = quo_ff[0];
   assign base_col = quo_ff[1];
   assign last_row = last_ff[0];
   assign last_col = last_ff[1];

endmodule

`default_nettype wire

>>> rtl/core/icbad_div.sv
// Pipelined restoring divider: one quotient bit per stage, block sum over pixel count.
`default_nettype none

module icbad_div import icbad_pkg::*; #(
   parameter int SUM_W = 34,
   parameter int CNT_W = 26,
   parameter int Q_W   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [SUM_W-1:0] in_sum,
   input  logic [CNT_W-1:0] in_cnt,
   input  cell_tag_type     in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quot,
   output cell_tag_type     out_tag
);

   logic             v_ff [Q_W];
   logic             v_in [Q_W];
   logic [SUM_W-1:0] r_ff [Q_W];
   logic [SUM_W-1:0] r_in [Q_W];
   logic [CNT_W-1:0] d_ff [Q_W];
   logic [CNT_W-1:0] d_in [Q_W];
   logic [Q_W-1:0]   q_ff [Q_W];
   logic [Q_W-1:0]   q_in [Q_W];
   cell_tag_type     t_ff [Q_W];
   cell_tag_type     t_in [Q_W];

   // quotient always fits Q_W bits: the mean never exceeds the largest pixel
   always_comb begin
      logic             v_p;
      logic [SUM_W-1:0] r_p;
      logic [CNT_W-1:0] d_p;
      logic [Q_W-1:0]   q_p;
      cell_tag_type     t_p;
      logic [SUM_W-1:0] trial;
      logic             ge;
      int               prev;
      for (int k = 0; k < Q_W; k++) begin
         prev = (k > 0) ? k - 1 : 0;
         if (k == 0) begin
            v_p = in_valid;
            r_p = in_sum;
            d_p = in_cnt;
            q_p = '0;
            t_p = in_tag;
         end else begin
            v_p = v_ff[prev];
            r_p = r_ff[prev];
            d_p = d_ff[prev];
            q_p = q_ff[prev];
            t_p = t_ff[prev];
         end
         trial   = SUM_W'(d_p) << (Q_W - 1 - k);
         ge      = (r_p >= trial);
         v_in[k] = v_p;
         d_in[k] = d_p;
         t_in[k] = t_p;
         r_in[k] = ge ? (r_p - trial) : r_p;
         q_in[k] = q_p | (ge ? (Q_W'(1) << (Q_W - 1 - k)) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Q_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff <= r_in;
         d_ff <= d_in;
         q_ff <= q_in;
         t_ff <= t_in;
      end
   end

   assign out_valid = v_ff[Q_W-1];
   assign out_quot  = q_ff[Q_W-1];
   assign out_tag   = t_ff[Q_W-1];

endmodule

`default_nettype wire

>>> rtl/core/icon_block_average_downscale.sv
// Top level of the block-average icon downscaler.
//
// Usage: a grayscale frame enters on req_if, one pixel per item, raster order from
// the top-left. Each completed source block produces one item on rsp_if carrying
// the icon cell coordinates, the truncated block mean and frame_done on the last
// cell. csr_if writes image_rows (index 0) or image_cols (index 1); any such write
// restarts the frame, other indexes are ignored. csr_if.ready is always high.
//
// Throughput: one pixel per cycle, sustained unless stalled or while block sizes
// are recomputed. Running sums live in a RAM with one entry per icon column,
// updated read-modify-write; back-to-back hits on one entry are covered by a
// forwarding register. Path of a cell after its final pixel: stage 1, stage 2,
// the one-bit-per-stage divider (Q_W = min(PIXEL_BITS, 8) bits), the output register.
//
// Reset and register writes: req_if.ready stays low while the block width and
// height are worked out: clamp, multiply by the reciprocal of ICON_SIZE, then
// the leftover size of the last block. Sums are marked empty by per-entry valid
// bits.
// Stall: results wait in the output register; only when it is full, not taken and
// another result leaves the divider does the whole pipeline, input included, freeze.
`default_nettype none

module icon_block_average_downscale import icbad_pkg::*; #(
   parameter int ICON_SIZE  = 64,
   parameter int PIXEL_BITS = 8,
   parameter int MAX_DIM    = 4096
) (
   input  logic          clock,
   input  logic          reset,
   icbad_csr_if.sink     csr_if,
   icbad_req_if.sink     req_if,
   icbad_rsp_if.source   rsp_if
);

   localparam int ADDR_W = $clog2(ICON_SIZE);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int PIX_W  = (PIXEL_BITS < PIXEL_IN_W) ? PIXEL_BITS : PIXEL_IN_W;
   localparam int CNT_W  = 2 * DIM_W;
   localparam int SUM_W  = CNT_W + PIX_W;
   localparam logic [ADDR_W-1:0] BLK_LAST = ADDR_W'(ICON_SIZE - 1);

   // geometry
   logic             restart;
   logic             geom_busy;
   logic [DIM_W-1:0] rows, cols, base_row, last_row, base_col, last_col;

   // raster position
   logic [DIM_W-1:0]  line_ff, line_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  lib_ff, lib_in;
   logic [DIM_W-1:0]  cib_ff, cib_in;
   logic [ADDR_W-1:0] br_ff, br_in;
   logic [ADDR_W-1:0] bc_ff, bc_in;

   logic [DIM_W-1:0] bh, bw;
   logic             col_end, line_end, line_wrap, frame_wrap;
   logic             accept, stall;
   cell_tag_type     tag0;

   // stage 1: RAM data back, add pixel, write back
   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [PIX_W-1:0]  s1_px_ff;
   logic              s1_emit_ff;
   logic [DIM_W-1:0]  s1_bh_ff, s1_bw_ff;
   cell_tag_type      s1_tag_ff;

   logic [SUM_W-1:0]  rd_data, old_sum, new_sum, wr_data;
   logic              wr_en, fwd;
   logic [CNT_W-1:0]  s1_cnt;
   logic [ICON_SIZE-1:0] sum_valid_ff;

   // write of the previous advancing cycle, seen stale by the read issued with it
   logic              hold_valid_ff;
   logic [ADDR_W-1:0] hold_addr_ff;
   logic [SUM_W-1:0]  hold_data_ff;

   // stage 2: divider input
   logic             s2_valid_ff;
   logic [SUM_W-1:0] s2_sum_ff;
   logic [CNT_W-1:0] s2_cnt_ff;
   cell_tag_type     s2_tag_ff;

   logic             div_valid;
   logic [PIX_W-1:0] div_quot;
   cell_tag_type     div_tag;

   // output register
   logic              out_valid_ff;
   logic [MEAN_W-1:0] out_mean_ff;
   cell_tag_type      out_tag_ff;

   icbad_geom #(
      .ICON_SIZE (ICON_SIZE),
      .MAX_DIM   (MAX_DIM),
      .DIM_W     (DIM_W)
   ) u_geom (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.wdata),
      .restart  (restart),
      .busy     (geom_busy),
      .rows     (rows),
      .cols     (cols),
      .base_row (base_row),
      .last_row (last_row),
      .base_col (base_col),
      .last_col (last_col)
   );

   assign csr_if.ready = 1'b1;

   // freeze only when a finished cell has nowhere to go
   assign stall        = out_valid_ff && !rsp_if.ready && div_valid;
   assign req_if.ready = !geom_busy && !stall;
   assign accept       = req_if.valid && req_if.ready;

   // block extents: last block row/column absorbs the remainder
   assign bh = (br_ff == BLK_LAST) ? last_row : base_row;
   assign bw = (bc_ff == BLK_LAST) ? last_col : base_col;

   assign col_end    = ({1'b0, cib_ff} + 1'b1) >= {1'b0, bw};
   assign line_end   = ({1'b0, lib_ff} + 1'b1) >= {1'b0, bh};
   assign line_wrap  = ({1'b0, col_ff} + 1'b1) >= {1'b0, cols};
   assign frame_wrap = ({1'b0, line_ff} + 1'b1) >= {1'b0, rows};

   always_comb begin
      tag0.icon_row   = ROW_W'(br_ff);
      tag0.icon_col   = COL_W'(bc_ff);
      tag0.frame_done = (br_ff == BLK_LAST) && (bc_ff == BLK_LAST);
   end

   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      lib_in  = lib_ff;
      cib_in  = cib_ff;
      br_in   = br_ff;
      bc_in   = bc_ff;
      if (restart) begin
         line_in = '0;
         col_in  = '0;
         lib_in  = '0;
         cib_in  = '0;
         br_in   = '0;
         bc_in   = '0;
      end else if (accept) begin
         if (line_wrap) begin
            col_in = '0;
            cib_in = '0;
            bc_in  = '0;
            if (frame_wrap) begin
               line_in = '0;
               lib_in  = '0;
               br_in   = '0;
            end else begin
               line_in = line_ff + 1'b1;
               if (line_end) begin
                  lib_in = '0;
                  br_in  = br_ff + 1'b1;
               end else begin
                  lib_in = lib_ff + 1'b1;
               end
            end
         end else begin
            col_in = col_ff + 1'b1;
            if (col_end) begin
               cib_in = '0;
               bc_in  = bc_ff + 1'b1;
            end else begin
               cib_in = cib_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
         col_ff  <= '0;
         lib_ff  <= '0;
         cib_ff  <= '0;
         br_ff   <= '0;
         bc_ff   <= '0;
      end else begin
         line_ff <= line_in;
         col_ff  <= col_in;
         lib_ff  <= lib_in;
         cib_ff  <= cib_in;
         br_ff   <= br_in;
         bc_ff   <= bc_in;
      end
   end

   // sum RAM: read issued at accept, written back from stage 1 when not stalled
   icbad_ram #(
      .WIDTH (SUM_W),
      .DEPTH (ICON_SIZE)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (bc_ff),
      .rd_data (rd_data)
   );

   assign fwd     = hold_valid_ff && (hold_addr_ff == s1_addr_ff);
   assign old_sum = fwd ? hold_data_ff :
                    (sum_valid_ff[s1_addr_ff] ? rd_data : '0);
   assign new_sum = old_sum + SUM_W'(s1_px_ff);
   // emitted block leaves a zero sum behind for the next block row
   assign wr_data = s1_emit_ff ? '0 : new_sum;
   assign wr_en   = s1_valid_ff && !stall;
   assign s1_cnt  = CNT_W'(s1_bh_ff) * CNT_W'(s1_bw_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         sum_valid_ff  <= '0;
      end else begin
         if (!stall) begin
            s1_valid_ff   <= accept;
            s2_valid_ff   <= s1_valid_ff && s1_emit_ff;
            hold_valid_ff <= s1_valid_ff;
         end
         if (restart) begin
            sum_valid_ff <= '0;
         end else if (wr_en) begin
            sum_valid_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= bc_ff;
         s1_px_ff   <= req_if.pixel[PIX_W-1:0];
         s1_emit_ff <= col_end && line_end;
         s1_bh_ff   <= bh;
         s1_bw_ff   <= bw;
         s1_tag_ff  <= tag0;
      end
      if (!stall) begin
         hold_addr_ff <= s1_addr_ff;
         hold_data_ff <= wr_data;
         s2_sum_ff    <= new_sum;
         s2_cnt_ff    <= s1_cnt;
         s2_tag_ff    <= s1_tag_ff;
      end
   end

   icbad_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W),
      .Q_W   (PIX_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (!stall),
      .in_valid  (s2_valid_ff),
      .in_sum    (s2_sum_ff),
      .in_cnt    (s2_cnt_ff),
      .in_tag    (s2_tag_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_if.ready) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if ((!out_valid_ff || rsp_if.ready) && div_valid) begin
         out_mean_ff <= MEAN_W'(div_quot);
         out_tag_ff  <= div_tag;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.icon_row   = out_tag_ff.icon_row;
   assign rsp_if.icon_col   = out_tag_ff.icon_col;
   assign rsp_if.mean_level = out_mean_ff;
   assign rsp_if.frame_done = out_tag_ff.frame_done;

endmodule

`default_nettype wire

>>> rtl/core/icbad_checker.sv
// Port-level checker for the downscaler, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module icbad_checker import icbad_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [ROW_W-1:0]     rsp_icon_row,
   input logic [COL_W-1:0]     rsp_icon_col,
   input logic [MEAN_W-1:0]    rsp_mean_level,
   input logic                 rsp_frame_done
);

   // a waiting cell holds until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_icon_row) && $stable(rsp_icon_col) && $stable(rsp_mean_level) && $stable(rsp_frame_done), "rsp item changed while stalled")

   // frame_done only on a cell whose icon row equals its icon column
   `ASSERT_IMPLIES(a_done_corner, clock, reset, rsp_valid && rsp_frame_done, rsp_icon_row == rsp_icon_col, "frame_done off the corner cell")

   // a dimension write blocks pixels while block sizes are recomputed
   `ASSERT_NEXT(a_cfg_blocks, clock, reset, csr_valid && csr_ready && (csr_index == REG_IMAGE_ROWS || csr_index == REG_IMAGE_COLS), !req_ready, "pixel taken right after a dimension write")

endmodule

bind icon_block_average_downscale icbad_checker u_icbad_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .csr_valid      (csr_if.valid),
   .csr_ready      (csr_if.ready),
   .csr_index      (csr_if.index),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_icon_row   (rsp_if.icon_row),
   .rsp_icon_col   (rsp_if.icon_col),
   .rsp_mean_level (rsp_if.mean_level),
   .rsp_frame_done (rsp_if.frame_done)
);

`default_nettype wire
